### design/cpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpf_pkg
// Types, codes and the CRC-7 byte fold shared by the command packet framer.
// ----------------------------------------------------------------------------
package cpf_pkg;

    // Item kind codes
    localparam logic [1:0] KIND_COMMAND = 2'd0;
    localparam logic [1:0] KIND_DATA    = 2'd1;
    localparam logic [1:0] KIND_VALUE   = 2'd2;

    // Configuration register indexes
    localparam logic REG_DEVICE_NUMBER   = 1'b0;
    localparam logic REG_CHECKSUM_ENABLE = 1'b1;

    // Reset values of the configuration registers
    localparam logic [7:0] DEVICE_NUMBER_RESET   = 8'd12;
    localparam logic       CHECKSUM_ENABLE_RESET = 1'b0;

    // Packet constants
    localparam logic [7:0] HEADER_BYTE = 8'hAA;
    localparam logic [7:0] CRC_POLY    = 8'h91;

    // Width of the configuration data port (widest register)
    localparam int CFG_DATA_W = 8;

    typedef struct packed {
        logic [1:0]  kind;
        logic [13:0] value;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_item_t;

    // Fold one byte into the reflected CRC-7, one bit per step, LSB first
    function automatic logic [6:0] crc_fold(input logic [6:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = {1'b0, crc} ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = c ^ CRC_POLY;
            end
            c = {1'b0, c[7:1]};
        end
        return c[6:0];
    endfunction

endpackage

### design/command_packet_framer_crc7_top.sv
`timescale 1ns / 1ps
// An accepted item is held in the item register, and its bytes move one by one
// to the output register, one byte per cycle unless out_ready stalls. Bytes:
// command 3, data 1, value 2, plus a CRC byte on a last item if checksum is on.
// Kind 3 items are taken and dropped. The next item is accepted in
// the cycle that the current item's final byte moves to the output register.
// Reset: device number 12, checksum off, running CRC zero, both channels empty.
// ----------------------------------------------------------------------------
// command_packet_framer_crc7_top
// Turns command, data and 14-bit value items into a serial byte stream with
// header, device number and an optional trailing CRC-7 byte per packet.
// ----------------------------------------------------------------------------
module command_packet_framer_crc7_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  cpf_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output cpf_pkg::out_item_t            out_data,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [cpf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cpf_pkg::*;

    logic [7:0] device_number_reg;
    logic       checksum_enable_reg;

    in_item_t   item_reg;
    logic       item_valid_reg;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic [6:0] crc_reg;
    logic [6:0] crc_next;
    logic [6:0] crc_in;

    out_item_t  out_reg;
    logic       out_valid_reg;

    logic [2:0] base_count;
    logic [2:0] total_count;
    logic [7:0] cur_byte;
    logic       is_crc_byte;
    logic       is_final;
    logic       advance;
    logic       in_take;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_number_reg   <= DEVICE_NUMBER_RESET;
            checksum_enable_reg <= CHECKSUM_ENABLE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEVICE_NUMBER:   device_number_reg   <= cfg_data[7:0];
                REG_CHECKSUM_ENABLE: checksum_enable_reg <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // Decode byte count of the held item
    always_comb
    begin
        case (item_reg.kind)
            KIND_COMMAND: base_count = 3'd3;
            KIND_DATA:    base_count = 3'd1;
            KIND_VALUE:   base_count = 3'd2;
            default:      base_count = 3'd0;
        endcase
        total_count = base_count + {2'b00, item_reg.last & checksum_enable_reg};
        is_crc_byte = ({1'b0, idx_reg} == base_count);
        is_final    = (({1'b0, idx_reg} + 3'd1) == total_count);
    end

    // Select the current byte and fold it into the CRC
    always_comb
    begin
        cur_byte = item_reg.value[7:0];
        case (item_reg.kind)
            KIND_COMMAND:
            begin
                case (idx_reg)
                    2'd0:    cur_byte = HEADER_BYTE;
                    2'd1:    cur_byte = device_number_reg;
                    default: cur_byte = item_reg.value[7:0];
                endcase
            end
            KIND_VALUE:
            begin
                if (idx_reg == 2'd0)
                begin
                    cur_byte = {1'b0, item_reg.value[6:0]};
                end
                else
                begin
                    cur_byte = {1'b0, item_reg.value[13:7]};
                end
            end
            default: cur_byte = item_reg.value[7:0];
        endcase
        if (is_crc_byte)
        begin
            cur_byte = {1'b0, crc_reg};
        end

        // A command restarts the CRC from zero
        if (item_reg.kind == KIND_COMMAND && idx_reg == 2'd0)
        begin
            crc_in = 7'd0;
        end
        else
        begin
            crc_in = crc_reg;
        end

        if (is_final && item_reg.last)
        begin
            crc_next = 7'd0;
        end
        else
        begin
            crc_next = crc_fold(crc_in, cur_byte);
        end
    end

    // Handshake control
    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || (advance && is_final);
    assign in_take  = in_valid && in_ready && (in_data.kind == KIND_COMMAND ||
                      in_data.kind == KIND_DATA || in_data.kind == KIND_VALUE);
    assign idx_next = (advance && !is_final) ? idx_reg + 2'd1 : 2'd0;

    // Item register, byte index and running CRC; drop unused kinds at the input
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            idx_reg        <= 2'd0;
            crc_reg        <= 7'd0;
        end
        else
        begin
            if (advance)
            begin
                crc_reg <= crc_next;
                idx_reg <= idx_next;
            end
            if (in_ready)
            begin
                item_valid_reg <= in_take;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= in_data;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.out_byte <= cur_byte;
            out_reg.out_last <= is_final && item_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### sim/tb_command_packet_framer_crc7_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_command_packet_framer_crc7_top
// Self-checking bench for the command packet framer. Command, data and value
// items go in through a valid/ready driver fed from a queue. Each accepted
// item is framed by a local byte model with its own CRC-7. The output bytes
// are checked in order against the predicted bytes while both sides idle at
// random and the framer is configured between phases.
// ----------------------------------------------------------------------------
module tb_command_packet_framer_crc7_top;

    import cpf_pkg::*;

    // Reserved kind code, dropped by the framer
    localparam logic [1:0] KIND_UNUSED   = 2'd3;
    localparam int         FREEZE_CYCLES = 240;
    localparam int         PHASES        = 8;
    localparam int         PHASE_ITEMS   = 48;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_item_t              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  cfg_we = 1'b0;
    logic                  cfg_index = REG_DEVICE_NUMBER;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Framer model state
    logic [7:0]            dev_num = DEVICE_NUMBER_RESET;
    logic                  crc_on = CHECKSUM_ENABLE_RESET;
    logic [6:0]            pkt_crc = 7'd0;

    in_item_t              cmd_items_q[$];
    out_item_t             packet_bytes_q[$];

    int                    mismatches = 0;
    bit                    in_fired = 1'b0;
    bit                    out_fired = 1'b0;
    bit                    tx_lazy = 1'b0;
    bit                    rx_lazy = 1'b0;
    bit                    freeze_req = 1'b0;
    int                    freeze_left = 0;
    int                    tx_gap = 0;
    int                    rx_wait = 0;

    command_packet_framer_crc7_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Fold one byte into the reflected CRC-7, shifting out the LSB each step
    function automatic logic [6:0] crc7_absorb(input logic [6:0] crc, input logic [7:0] b);
        logic [7:0] acc;
        acc = {1'b0, crc} ^ b;
        for (int k = 0; k < 8; k++)
        begin
            acc = (acc >> 1) ^ (acc[0] ? 8'h48 : 8'h00);
        end
        return acc[6:0];
    endfunction

    // Predict the bytes that one item adds to the packet stream
    function automatic void frame_item(input in_item_t it);
        logic [7:0] bytes [0:2];
        int         n;
        out_item_t  ob;
        n = 0;
        case (it.kind)
            KIND_COMMAND:
            begin
                pkt_crc  = 7'd0;
                bytes[0] = HEADER_BYTE;
                bytes[1] = dev_num;
                bytes[2] = it.value[7:0];
                n = 3;
            end
            KIND_DATA:
            begin
                bytes[0] = it.value[7:0];
                n = 1;
            end
            KIND_VALUE:
            begin
                bytes[0] = {1'b0, it.value[6:0]};
                bytes[1] = {1'b0, it.value[13:7]};
                n = 2;
            end
            default:
            begin
                n = 0;
            end
        endcase
        for (int k = 0; k < n; k++)
        begin
            pkt_crc     = crc7_absorb(pkt_crc, bytes[k]);
            ob.out_byte = bytes[k];
            ob.out_last = it.last && !crc_on && (k == n - 1);
            packet_bytes_q.push_back(ob);
        end
        // Close the packet, appending the checksum when enabled
        if (n > 0 && it.last)
        begin
            if (crc_on)
            begin
                ob.out_byte = {1'b0, pkt_crc};
                ob.out_last = 1'b1;
                packet_bytes_q.push_back(ob);
            end
            pkt_crc = 7'd0;
        end
    endfunction

    // Track config writes and accepted items; check every output transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_DEVICE_NUMBER)
                begin
                    dev_num = cfg_data[7:0];
                end
                else
                begin
                    crc_on = cfg_data[0];
                end
            end
            if (in_valid && in_ready)
            begin
                in_fired = 1'b1;
                frame_item(in_data);
            end
            if (out_valid && out_ready)
            begin
                out_fired = 1'b1;
                if (packet_bytes_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected byte: expected none, actual byte %02h last %0b",
                             $time, out_data.out_byte, out_data.out_last);
                end
                else
                begin
                    out_item_t want;
                    want = packet_bytes_q.pop_front();
                    if (out_data.out_byte !== want.out_byte)
                    begin
                        mismatches++;
                        $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                                 $time, want.out_byte, out_data.out_byte);
                    end
                    if (out_data.out_last !== want.out_last)
                    begin
                        mismatches++;
                        $display("%0t: out_last mismatch: expected %0b, actual %0b",
                                 $time, want.out_last, out_data.out_last);
                    end
                end
            end
        end
    end

    // Drive items from the pending queue, holding each until accepted
    always @(negedge clk)
    begin
        if (!(in_valid && !in_fired))
        begin
            if (tx_gap > 0)
            begin
                tx_gap--;
                in_valid <= 1'b0;
            end
            else if (cmd_items_q.size() > 0)
            begin
                in_data  <= cmd_items_q.pop_front();
                in_valid <= 1'b1;
                tx_gap = tx_lazy ? $urandom_range(0, 10) : 0;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        in_fired = 1'b0;
    end

    // Drive ready, with per-byte stalls and an occasional long freeze
    always @(negedge clk)
    begin
        if (freeze_req)
        begin
            freeze_left = FREEZE_CYCLES;
            freeze_req  = 1'b0;
        end
        if (out_fired)
        begin
            rx_wait = rx_lazy ? $urandom_range(0, 10) : 0;
        end
        out_fired = 1'b0;
        if (freeze_left > 0)
        begin
            freeze_left--;
            out_ready <= 1'b0;
        end
        else if (rx_wait > 0)
        begin
            rx_wait--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    task automatic queue_item(input logic [1:0] kind, input logic [13:0] value,
                              input logic last);
        in_item_t it;
        it.kind  = kind;
        it.value = value;
        it.last  = last;
        cmd_items_q.push_back(it);
    endtask

    // Write both registers back to back, then release the write enable
    task automatic program_regs(input logic [7:0] dev, input logic ck);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DEVICE_NUMBER;
        cfg_data  <= dev;
        @(negedge clk);
        cfg_index <= REG_CHECKSUM_ENABLE;
        cfg_data  <= {7'd0, ck};
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Wait until every queued item is sent and every predicted byte has come out
    task automatic wait_idle();
        while (cmd_items_q.size() > 0 || in_valid || packet_bytes_q.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    // Queue one packet: mostly well formed, some noise and broken framing
    task automatic queue_packet(inout int count);
        int body;
        int pick;
        body = $urandom_range(0, 4);
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            queue_item(KIND_UNUSED, 14'($urandom_range(0, 16383)),
                       1'($urandom_range(0, 1)));
            count++;
        end
        else if (pick == 1)
        begin
            // Data with no command in front
            queue_item(KIND_DATA, 14'($urandom_range(0, 16383)),
                       1'($urandom_range(0, 1)));
            count++;
        end
        else
        begin
            queue_item(KIND_COMMAND, 14'($urandom_range(0, 16383)), body == 0);
            count++;
            for (int k = 0; k < body; k++)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    queue_item(KIND_UNUSED, 14'($urandom_range(0, 16383)),
                               1'($urandom_range(0, 1)));
                    count++;
                end
                queue_item($urandom_range(0, 1) ? KIND_VALUE : KIND_DATA,
                           14'($urandom_range(0, 16383)),
                           (k == body - 1) ? (pick != 2) : 1'b0);
                count++;
            end
        end
    endtask

    initial
    begin
        int count;
        logic [7:0] dev;
        logic ck;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset config, extremes, kind 3, data with no command
        tx_lazy = 1'b0;
        rx_lazy = 1'b0;
        queue_item(KIND_COMMAND, 14'h0000, 1'b0);
        queue_item(KIND_DATA, 14'h00FF, 1'b0);
        queue_item(KIND_VALUE, 14'h3FFF, 1'b1);
        queue_item(KIND_COMMAND, 14'h3FFF, 1'b1);
        queue_item(KIND_UNUSED, 14'h3FFF, 1'b1);
        queue_item(KIND_VALUE, 14'h2AAA, 1'b0);
        queue_item(KIND_DATA, 14'h3F00, 1'b1);
        queue_item(KIND_VALUE, 14'h0000, 1'b1);
        queue_item(KIND_UNUSED, 14'h0000, 1'b0);
        wait_idle();

        program_regs(8'hFF, 1'b1);
        queue_item(KIND_COMMAND, 14'h0080, 1'b0);
        queue_item(KIND_VALUE, 14'h1555, 1'b0);
        queue_item(KIND_UNUSED, 14'h1555, 1'b0);
        queue_item(KIND_DATA, 14'h00A5, 1'b1);
        queue_item(KIND_COMMAND, 14'h00FF, 1'b1);
        queue_item(KIND_DATA, 14'h0001, 1'b1);
        queue_item(KIND_VALUE, 14'h3FFF, 1'b1);
        wait_idle();

        program_regs(8'h00, 1'b1);
        queue_item(KIND_COMMAND, 14'h0000, 1'b1);
        queue_item(KIND_VALUE, 14'h0000, 1'b1);
        wait_idle();

        // Random phases, each with its own config and idling mix
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       begin dev = 8'h00; ck = 1'b0; end
                1:       begin dev = 8'hFF; ck = 1'b1; end
                2:       begin dev = 8'hFF; ck = 1'b0; end
                3:       begin dev = 8'h00; ck = 1'b1; end
                default:
                begin
                    dev = 8'($urandom_range(0, 255));
                    ck  = 1'($urandom_range(0, 1));
                end
            endcase
            program_regs(dev, ck);
            tx_lazy = (p == 2) ? 1'b0 : 1'($urandom_range(0, 1));
            rx_lazy = (p == 0) ? 1'b0 : 1'($urandom_range(0, 1));
            count = 0;
            while (count < PHASE_ITEMS)
            begin
                queue_packet(count);
            end
            // Freeze the receiver while the sender keeps offering items
            if (p == 2)
            begin
                freeze_req = 1'b1;
            end
            wait_idle();
        end

        if (mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Abort a hung run
    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
